// File: hdl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// Perfect number test package
// Shared widths, limits and the divider status bundle.
// ----------------------------------------------------------------------------
package pnt_pkg;

  localparam int CAND_W         = 16;
  localparam int SUM_OUT_W      = 18;
  localparam int VALUE_BITS_DEF = 16;

  localparam logic [SUM_OUT_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

// File: hdl/pnt_div.sv
// ----------------------------------------------------------------------------
// Perfect number test remainder unit
// Restoring shift-subtract divider that produces one remainder bit per cycle.
// ----------------------------------------------------------------------------
module pnt_div #(
  parameter int DATA_W = pnt_pkg::CAND_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [DATA_W-1:0]   dividend,
  input  logic [DATA_W-1:0]   divisor,
  output pnt_pkg::div_status_t status
);
  import pnt_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic [DATA_W:0]   rem_shift;

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    rem_shift = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DATA_W);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (run_r) begin
      if (rem_shift >= {1'b0, div_r}) begin
        rem_nxt = rem_shift - {1'b0, div_r};
      end else begin
        rem_nxt = rem_shift;
      end
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign status.busy     = run_r;
  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// File: hdl/pnt_seq.sv
// ----------------------------------------------------------------------------
// Perfect number test sequencer
// Steps the trial divisor, accumulates the divisor sum and issues the result.
// ----------------------------------------------------------------------------
module pnt_seq #(
  parameter int DATA_W = pnt_pkg::CAND_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DATA_W-1:0]             value,
  output logic                          busy,
  output logic                          div_go,
  output logic [DATA_W-1:0]             div_dividend,
  output logic [DATA_W-1:0]             div_divisor,
  input  pnt_pkg::div_status_t          div_status,
  output logic                          out_valid,
  output logic                          out_is_perfect,
  output logic [pnt_pkg::SUM_OUT_W-1:0] out_divisor_sum
);
  import pnt_pkg::*;

  localparam int SUM_W = DATA_W + 3;
  localparam int CMP_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [DATA_W-1:0]    n_r, n_nxt;
  logic [DATA_W-1:0]    half_r, half_nxt;
  logic [DATA_W-1:0]    d_r, d_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SUM_W-1:0]     sum_upd;
  logic [CMP_W-1:0]     sum_ext;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_is_perfect_r, out_is_perfect_nxt;
  logic [SUM_OUT_W-1:0] out_divisor_sum_r, out_divisor_sum_nxt;

  always_comb begin
    state_nxt           = state_r;
    n_nxt               = n_r;
    half_nxt            = half_r;
    d_nxt               = d_r;
    sum_nxt             = sum_r;
    out_valid_nxt       = 1'b0;
    out_is_perfect_nxt  = out_is_perfect_r;
    out_divisor_sum_nxt = out_divisor_sum_r;
    sum_upd             = sum_r + (div_status.rem_zero ? SUM_W'(d_r) : '0);
    sum_ext             = CMP_W'(sum_upd);
    div_go              = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt    = value;
          half_nxt = value >> 1;
          d_nxt    = DATA_W'(1);
          sum_nxt  = '0;
          if ((value >> 1) == '0) begin
            out_valid_nxt       = 1'b1;
            out_is_perfect_nxt  = 1'b0;
            out_divisor_sum_nxt = '0;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        div_go    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_status.done) begin
          sum_nxt = sum_upd;
          if (d_r == half_r) begin
            state_nxt           = ST_IDLE;
            out_valid_nxt       = 1'b1;
            out_is_perfect_nxt  = (sum_upd == SUM_W'(n_r));
            out_divisor_sum_nxt = (sum_ext > CMP_W'(SUM_MAX)) ? SUM_MAX
                                                              : sum_ext[SUM_OUT_W-1:0];
          end else begin
            d_nxt     = d_r + DATA_W'(1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r               <= n_nxt;
    half_r            <= half_nxt;
    d_r               <= d_nxt;
    sum_r             <= sum_nxt;
    out_is_perfect_r  <= out_is_perfect_nxt;
    out_divisor_sum_r <= out_divisor_sum_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign div_dividend    = n_r;
  assign div_divisor     = d_r;
  assign out_valid       = out_valid_r;
  assign out_is_perfect  = out_is_perfect_r;
  assign out_divisor_sum = out_divisor_sum_r;

endmodule

// File: hdl/perfect_number_test.sv
// ----------------------------------------------------------------------------
// Perfect number test
// Sums the proper divisors of a value by trial division and flags a match.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transaction
//  input   | start, busy, in_candidate               | start high while busy low
//  result  | out_valid, out_is_perfect,              | out_valid high for one cycle
//          | out_divisor_sum                         |
//
// A value n keeps busy high while each trial divisor from one to floor(n/2)
// passes once through the shared serial remainder unit, which resolves one
// bit per cycle; out_valid rises in the same cycle in which busy falls.
// Values below two give their result in the cycle after the transaction.
// Reset clears the sequencer and the divider control. The receiver cannot
// stall; busy is high while a value is in work.
// ----------------------------------------------------------------------------
module perfect_number_test #(
  parameter int VALUE_BITS = pnt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pnt_pkg::CAND_W-1:0]    in_candidate,
  output logic                          out_valid,
  output logic                          out_is_perfect,
  output logic [pnt_pkg::SUM_OUT_W-1:0] out_divisor_sum
);
  import pnt_pkg::*;

  localparam int N_W = (VALUE_BITS < CAND_W) ? VALUE_BITS : CAND_W;

  logic              div_go;
  logic [N_W-1:0]    div_dividend;
  logic [N_W-1:0]    div_divisor;
  div_status_t       div_status;

  pnt_seq #(
    .DATA_W (N_W)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .value           (in_candidate[N_W-1:0]),
    .busy            (busy),
    .div_go          (div_go),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_status      (div_status),
    .out_valid       (out_valid),
    .out_is_perfect  (out_is_perfect),
    .out_divisor_sum (out_divisor_sum)
  );

  pnt_div #(
    .DATA_W (N_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("Accepted transaction neither started work nor produced a result.");

  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |=> div_status.busy && !div_status.done)
    else $error("Remainder unit did not start after being launched.");

  a_perfect_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_perfect |-> out_divisor_sum != '0)
    else $error("Perfect flag raised with an empty divisor sum.");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !div_status.busy)
    else $error("Remainder unit active while the sequencer is idle.");

endmodule
